[sv/tos_pkg.sv]
`default_nettype none

package tos_pkg;

  // Stack actions carried by an input word
  typedef enum logic [2:0] {
    TOS_ACT_PUSH   = 3'd0,
    TOS_ACT_POP    = 3'd1,
    TOS_ACT_DUP    = 3'd2,
    TOS_ACT_SWAP   = 3'd3,
    TOS_ACT_CLEAR  = 3'd4,
    TOS_ACT_ASSERT = 3'd5
  } tos_action_e;

  // Error codes reported with every result
  typedef enum logic [2:0] {
    TOS_ERR_OK       = 3'd0,
    TOS_ERR_EMPTY    = 3'd1,
    TOS_ERR_FEW      = 3'd2,
    TOS_ERR_MISMATCH = 3'd3,
    TOS_ERR_FULL     = 3'd4
  } tos_err_e;

  // Movement applied to the whole cell chain in one cycle
  typedef enum logic [2:0] {
    TOS_CH_HOLD,
    TOS_CH_PUSH,
    TOS_CH_DUP,
    TOS_CH_POP,
    TOS_CH_SWAP
  } tos_chain_op_e;

  localparam int unsigned TypeW  = 3;
  localparam int unsigned ValueW = 64;
  localparam int unsigned DepthW = 7;

  // One stack entry
  typedef struct packed {
    logic [TypeW-1:0]  entry_type;
    logic [ValueW-1:0] entry_value;
  } tos_entry_t;

  // Input word
  typedef struct packed {
    logic [2:0]        action;
    logic [TypeW-1:0]  operand_type;
    logic [ValueW-1:0] operand_value;
  } tos_in_t;

  // Result word
  typedef struct packed {
    logic [TypeW-1:0]  top_type;
    logic [ValueW-1:0] top_value;
    logic [DepthW-1:0] depth;
    logic [2:0]        error_code;
  } tos_out_t;

  // Control handed from the sequencer to every cell
  typedef struct packed {
    tos_chain_op_e op;
  } tos_ctl_t;

endpackage

`default_nettype wire

[sv/tos_cell.sv]
`default_nettype none

// One stack slot; cell 0 is the top of stack
module tos_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  wire                      clk_i,
  input  wire tos_pkg::tos_ctl_t   ctl_i,
  input  wire tos_pkg::tos_entry_t up_i,   // from the cell nearer the top (operand for cell 0)
  input  wire tos_pkg::tos_entry_t dn_i,   // from the cell deeper in the stack
  output tos_pkg::tos_entry_t      entry_o
);

  tos_pkg::tos_entry_t entry_q, entry_d;

  // Next entry by chain movement
  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      tos_pkg::TOS_CH_PUSH: entry_d = up_i;
      tos_pkg::TOS_CH_DUP: begin
        if (CellIdx != 0) entry_d = up_i;
      end
      tos_pkg::TOS_CH_POP: entry_d = dn_i;
      tos_pkg::TOS_CH_SWAP: begin
        if (CellIdx == 0) entry_d = dn_i;
        else if (CellIdx == 1) entry_d = up_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[sv/tos_ctrl.sv]
`default_nettype none

// Decodes the action, keeps the entry count and registers the result
module tos_ctrl #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      accept_i,
  input  wire tos_pkg::tos_in_t    item_i,
  input  wire tos_pkg::tos_entry_t top0_i,
  input  wire tos_pkg::tos_entry_t top1_i,
  output tos_pkg::tos_ctl_t        ctl_o,
  output logic                     done_o,
  output tos_pkg::tos_out_t        result_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  logic [CntW-1:0]     count_q, count_d;
  logic                done_q;
  tos_pkg::tos_out_t   result_q, result_d;
  tos_pkg::tos_entry_t res_entry, top_vis, zero_entry, operand;
  tos_pkg::tos_chain_op_e op;
  tos_pkg::tos_err_e   err;
  logic                empty, full, few;

  assign zero_entry = '0;
  assign operand    = '{entry_type: item_i.operand_type, entry_value: item_i.operand_value};
  assign empty      = (count_q == '0);
  assign full       = (count_q >= CntFull);
  assign few        = (count_q <= CntOne);
  assign top_vis    = empty ? zero_entry : top0_i;

  // Action decode
  always_comb begin
    op        = tos_pkg::TOS_CH_HOLD;
    count_d   = count_q;
    err       = tos_pkg::TOS_ERR_OK;
    res_entry = top_vis;
    unique case (item_i.action)
      tos_pkg::TOS_ACT_PUSH: begin
        if (full) begin
          err = tos_pkg::TOS_ERR_FULL;
        end else begin
          op        = tos_pkg::TOS_CH_PUSH;
          count_d   = count_q + CntOne;
          res_entry = operand;
        end
      end
      tos_pkg::TOS_ACT_POP: begin
        if (empty) begin
          err = tos_pkg::TOS_ERR_EMPTY;
        end else begin
          op        = tos_pkg::TOS_CH_POP;
          count_d   = count_q - CntOne;
          res_entry = top0_i;
        end
      end
      tos_pkg::TOS_ACT_DUP: begin
        if (empty) begin
          err = tos_pkg::TOS_ERR_EMPTY;
        end else if (full) begin
          err = tos_pkg::TOS_ERR_FULL;
        end else begin
          op      = tos_pkg::TOS_CH_DUP;
          count_d = count_q + CntOne;
        end
      end
      tos_pkg::TOS_ACT_SWAP: begin
        if (few) begin
          err = tos_pkg::TOS_ERR_FEW;
        end else begin
          op        = tos_pkg::TOS_CH_SWAP;
          res_entry = top1_i;
        end
      end
      tos_pkg::TOS_ACT_CLEAR: begin
        count_d   = '0;
        res_entry = zero_entry;
      end
      tos_pkg::TOS_ACT_ASSERT: begin
        if (empty) begin
          err = tos_pkg::TOS_ERR_EMPTY;
        end else if (top0_i != operand) begin
          err = tos_pkg::TOS_ERR_MISMATCH;
        end
      end
      default: ;  // undefined action: report top, no change
    endcase
  end

  assign ctl_o.op = accept_i ? op : tos_pkg::TOS_CH_HOLD;

  // Result word
  always_comb begin
    result_d.top_type   = res_entry.entry_type;
    result_d.top_value  = res_entry.entry_value;
    result_d.depth      = tos_pkg::DepthW'(count_d);
    result_d.error_code = err;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept_i;
      if (accept_i) count_q <= count_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept_i) result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

[sv/typed_operand_stack_top.sv]
// Typed operand stack built as a chain of shifting cells, cell 0 holding the top.
// Latency: result strobed on done_o in the cycle after the word is taken.
// Throughput: one word per cycle; a push, dup or pop shifts the whole chain and a swap
// exchanges the two top cells, all in the same cycle, so busy stays low.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst_ni low, asynchronous) empties the stack; cell contents are not cleared.
`default_nettype none

module typed_operand_stack_top #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start,
  output logic                   busy,
  input  wire tos_pkg::tos_in_t  item_i,
  output logic                   done_o,
  output tos_pkg::tos_out_t      result_o
);

  tos_pkg::tos_ctl_t   ctl;
  tos_pkg::tos_entry_t chain [STACK_DEPTH];
  tos_pkg::tos_entry_t operand;
  logic                accept;

  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign operand = '{entry_type: item_i.operand_type, entry_value: item_i.operand_value};

  // Sequencer
  tos_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (item_i),
    .top0_i  (chain[0]),
    .top1_i  (chain[1]),
    .ctl_o   (ctl),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // Cell chain
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    tos_pkg::tos_entry_t up, dn;
    if (g == 0) begin : g_first
      assign up = operand;
    end else begin : g_mid_up
      assign up = chain[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_last
      assign dn = chain[g];
    end else begin : g_mid_dn
      assign dn = chain[g+1];
    end
    tos_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .up_i   (up),
      .dn_i   (dn),
      .entry_o(chain[g])
    );
  end

endmodule

`default_nettype wire

[sv/tos_checker.sv]
`default_nettype none

// Port-level checks on the operand stack
module tos_checker (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    start,
  input wire                    busy,
  input wire tos_pkg::tos_in_t  item_i,
  input wire                    done_o,
  input wire tos_pkg::tos_out_t result_o
);

  logic acc;
  assign acc = start && !busy;

  // One result for every accepted word, in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> done_o)
    else $error("no result after accepted word");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> !done_o)
    else $error("result without accepted word");

  // Clear always empties with zero top
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && item_i.action == tos_pkg::TOS_ACT_CLEAR) |=>
      (result_o.depth == '0 && result_o.top_value == '0 &&
       result_o.top_type == '0 && result_o.error_code == tos_pkg::TOS_ERR_OK))
    else $error("clear result wrong");

  // A successful push shows the pushed operand on top
  a_push_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && item_i.action == tos_pkg::TOS_ACT_PUSH) |=>
      (result_o.error_code != tos_pkg::TOS_ERR_OK ||
       (result_o.top_value == $past(item_i.operand_value) &&
        result_o.top_type == $past(item_i.operand_type))))
    else $error("push top mismatch");

  // Error code stays within its defined codes
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.error_code <= tos_pkg::TOS_ERR_FULL))
    else $error("undefined error code");

endmodule

bind typed_operand_stack_top tos_checker u_tos_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .item_i  (item_i),
  .done_o  (done_o),
  .result_o(result_o)
);

`default_nettype wire

[verif/tb_typed_operand_stack_top.sv]
`default_nettype none

module tb_typed_operand_stack_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tos_pkg::*;

  localparam int unsigned STACK_DEPTH    = 64;
  localparam int unsigned N_WORDS        = 1250;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 4;

  // Action codes the block must ignore
  localparam logic [2:0] ACT_RSVD_6 = 3'd6;
  localparam logic [2:0] ACT_RSVD_7 = 3'd7;

  localparam logic [ValueW-1:0] VAL_MAX = '1;
  localparam logic [ValueW-1:0] VAL_ODD = 64'h8000_0000_0000_0001;

  // Flavor of one random burst
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED,
    MIX_NOISE
  } burst_mix_e;

  // One directed word, optionally with its result typed in
  typedef struct {
    tos_in_t  word;
    bit       typed;
    tos_out_t want;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  tos_in_t  item_i;
  logic     done_o;
  tos_out_t result_o;

  // Shadow copy of the stack
  logic [ValueW-1:0] shadow_val [STACK_DEPTH];
  logic [TypeW-1:0]  shadow_typ [STACK_DEPTH];
  int unsigned       shadow_cnt = 0;

  tos_out_t    pending_results [$];
  dir_row_t    dir_rows [$];
  int unsigned n_fail      = 0;
  int unsigned n_counted   = 0;
  int unsigned n_rsvd      = 0;
  int unsigned n_full      = 0;
  int unsigned n_match     = 0;
  int unsigned n_checked   = 0;
  int unsigned max_depth   = 0;
  int unsigned idle_cycles = 0;

  typed_operand_stack_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .item_i,
    .done_o,
    .result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic tos_out_t mk_res(logic [TypeW-1:0] t, logic [ValueW-1:0] v,
                                      int unsigned d, tos_err_e e);
    tos_out_t r;
    r.top_type   = t;
    r.top_value  = v;
    r.depth      = DepthW'(d);
    r.error_code = e;
    return r;
  endfunction

  function automatic tos_in_t mk_word(logic [2:0] a, logic [TypeW-1:0] t,
                                      logic [ValueW-1:0] v);
    tos_in_t w;
    w.action        = a;
    w.operand_type  = t;
    w.operand_value = v;
    return w;
  endfunction

  // Result that shows the current top of the shadow stack
  function automatic tos_out_t top_res(tos_err_e e);
    if (shadow_cnt == 0) begin
      return mk_res('0, '0, 0, e);
    end
    return mk_res(shadow_typ[shadow_cnt-1], shadow_val[shadow_cnt-1], shadow_cnt, e);
  endfunction

  // Apply one word to the shadow stack and return the result it yields
  function automatic tos_out_t stack_apply(tos_in_t w);
    tos_out_t          r;
    logic [ValueW-1:0] v;
    logic [TypeW-1:0]  k;
    case (w.action)
      TOS_ACT_PUSH: begin
        if (shadow_cnt >= STACK_DEPTH) begin
          r = top_res(TOS_ERR_FULL);
        end else begin
          shadow_val[shadow_cnt] = w.operand_value;
          shadow_typ[shadow_cnt] = w.operand_type;
          shadow_cnt++;
          r = top_res(TOS_ERR_OK);
        end
      end
      TOS_ACT_POP: begin
        if (shadow_cnt == 0) begin
          r = mk_res('0, '0, 0, TOS_ERR_EMPTY);
        end else begin
          shadow_cnt--;
          r = mk_res(shadow_typ[shadow_cnt], shadow_val[shadow_cnt], shadow_cnt,
                     TOS_ERR_OK);
        end
      end
      TOS_ACT_DUP: begin
        if (shadow_cnt == 0) begin
          r = top_res(TOS_ERR_EMPTY);
        end else if (shadow_cnt >= STACK_DEPTH) begin
          r = top_res(TOS_ERR_FULL);
        end else begin
          shadow_val[shadow_cnt] = shadow_val[shadow_cnt-1];
          shadow_typ[shadow_cnt] = shadow_typ[shadow_cnt-1];
          shadow_cnt++;
          r = top_res(TOS_ERR_OK);
        end
      end
      TOS_ACT_SWAP: begin
        if (shadow_cnt < 2) begin
          r = top_res(TOS_ERR_FEW);
        end else begin
          v = shadow_val[shadow_cnt-1];
          k = shadow_typ[shadow_cnt-1];
          shadow_val[shadow_cnt-1] = shadow_val[shadow_cnt-2];
          shadow_typ[shadow_cnt-1] = shadow_typ[shadow_cnt-2];
          shadow_val[shadow_cnt-2] = v;
          shadow_typ[shadow_cnt-2] = k;
          r = top_res(TOS_ERR_OK);
        end
      end
      TOS_ACT_CLEAR: begin
        shadow_cnt = 0;
        r = mk_res('0, '0, 0, TOS_ERR_OK);
      end
      TOS_ACT_ASSERT: begin
        if (shadow_cnt == 0) begin
          r = top_res(TOS_ERR_EMPTY);
        end else if (shadow_typ[shadow_cnt-1] == w.operand_type &&
                     shadow_val[shadow_cnt-1] == w.operand_value) begin
          r = top_res(TOS_ERR_OK);
        end else begin
          r = top_res(TOS_ERR_MISMATCH);
        end
      end
      // reserved actions leave the stack alone
      default: r = top_res(TOS_ERR_OK);
    endcase
    return r;
  endfunction

  function automatic logic [ValueW-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return VAL_MAX;
      2:       return 64'd1 << $urandom_range(0, ValueW-1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic tos_in_t rand_word(burst_mix_e mix);
    tos_in_t     w;
    int unsigned roll;
    int unsigned bit_idx;
    roll            = $urandom_range(0, 99);
    w.operand_type  = TypeW'($urandom_range(0, 7));
    w.operand_value = rand_value();
    case (mix)
      MIX_FILL: begin
        w.action = roll < 60 ? TOS_ACT_PUSH : roll < 75 ? TOS_ACT_DUP :
                   roll < 85 ? TOS_ACT_ASSERT : roll < 93 ? TOS_ACT_SWAP : TOS_ACT_POP;
      end
      MIX_DRAIN: begin
        w.action = roll < 60 ? TOS_ACT_POP : roll < 75 ? TOS_ACT_ASSERT :
                   roll < 85 ? TOS_ACT_SWAP : roll < 90 ? TOS_ACT_DUP : TOS_ACT_PUSH;
      end
      MIX_BALANCED: begin
        w.action = roll < 30 ? TOS_ACT_PUSH : roll < 55 ? TOS_ACT_POP :
                   roll < 65 ? TOS_ACT_DUP : roll < 80 ? TOS_ACT_SWAP :
                   roll < 95 ? TOS_ACT_ASSERT : TOS_ACT_CLEAR;
      end
      default: w.action = 3'($urandom_range(0, 7));
    endcase
    // aim most asserts at the live top, some as near misses
    if (w.action == TOS_ACT_ASSERT && shadow_cnt > 0 && $urandom_range(0, 3) != 0) begin
      w.operand_type  = shadow_typ[shadow_cnt-1];
      w.operand_value = shadow_val[shadow_cnt-1];
      bit_idx         = $urandom_range(0, ValueW-1);
      case ($urandom_range(0, 3))
        0:       w.operand_value[bit_idx] = ~w.operand_value[bit_idx];
        1:       w.operand_type = w.operand_type + 3'd1;
        default: ;
      endcase
    end
    return w;
  endfunction

  function automatic void add_row(logic [2:0] a, logic [TypeW-1:0] t, logic [ValueW-1:0] v,
                                  bit typed, tos_out_t want);
    dir_row_t row;
    row.word  = mk_word(a, t, v);
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // Offer one word after an idle gap; optionally wait for the pipe to empty first
  task automatic send_word(tos_in_t w, int unsigned gap, bit drain, bit typed,
                           tos_out_t want);
    tos_out_t r;
    if (gap > 0 || drain) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain) begin
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end
    end
    start  <= 1'b1;
    item_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    r = stack_apply(w);
    pending_results.push_back(typed ? want : r);
    if (w.action <= TOS_ACT_ASSERT) n_counted++;
    else n_rsvd++;
    if (r.error_code == TOS_ERR_FULL) n_full++;
    if (w.action == TOS_ACT_ASSERT && r.error_code == TOS_ERR_OK) n_match++;
    if (shadow_cnt > max_depth) max_depth = shadow_cnt;
  endtask

  function automatic void check_result(tos_out_t want, tos_out_t got);
    bit bad;
    bad = (got.top_type !== want.top_type) || (got.top_value !== want.top_value) ||
          (got.depth !== want.depth) || (got.error_code !== want.error_code);
    n_checked++;
    if (bad) begin
      n_fail++;
      $display("%0t: result mismatch: expected type %0d value %h depth %0d err %0d, ",
               $time, want.top_type, want.top_value, want.depth, want.error_code,
               "got type %0d value %h depth %0d err %0d",
               got.top_type, got.top_value, got.depth, got.error_code);
    end
  endfunction

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected result word, expected none, got %h", $time, result_o);
      end else begin
        check_result(pending_results.pop_front(), result_o);
      end
    end
  end

  // Watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, expected %0d more results", $time,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tos_in_t     w;
    burst_mix_e  mix;
    int unsigned burst_len;
    int unsigned roll;
    bit          no_idle;
    bit          drain;

    rst_ni <= 1'b0;
    start  <= 1'b0;
    item_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-stack errors, operand extremes, swap, reserved actions, clear
    add_row(TOS_ACT_POP,    3'd0, '0,      1'b1, mk_res(3'd0, '0, 0, TOS_ERR_EMPTY));
    add_row(TOS_ACT_DUP,    3'd0, '0,      1'b1, mk_res(3'd0, '0, 0, TOS_ERR_EMPTY));
    add_row(TOS_ACT_SWAP,   3'd0, '0,      1'b1, mk_res(3'd0, '0, 0, TOS_ERR_FEW));
    add_row(TOS_ACT_ASSERT, 3'd0, '0,      1'b1, mk_res(3'd0, '0, 0, TOS_ERR_EMPTY));
    add_row(TOS_ACT_PUSH,   3'd7, VAL_MAX, 1'b1, mk_res(3'd7, VAL_MAX, 1, TOS_ERR_OK));
    add_row(TOS_ACT_SWAP,   3'd0, '0,      1'b1, mk_res(3'd7, VAL_MAX, 1, TOS_ERR_FEW));
    add_row(TOS_ACT_ASSERT, 3'd7, VAL_MAX, 1'b1, mk_res(3'd7, VAL_MAX, 1, TOS_ERR_OK));
    add_row(TOS_ACT_ASSERT, 3'd6, VAL_MAX, 1'b1,
            mk_res(3'd7, VAL_MAX, 1, TOS_ERR_MISMATCH));
    add_row(TOS_ACT_ASSERT, 3'd7, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
            mk_res(3'd7, VAL_MAX, 1, TOS_ERR_MISMATCH));
    add_row(TOS_ACT_PUSH,   3'd0, '0,      1'b1, mk_res(3'd0, '0, 2, TOS_ERR_OK));
    add_row(TOS_ACT_SWAP,   3'd0, '0,      1'b1, mk_res(3'd7, VAL_MAX, 2, TOS_ERR_OK));
    add_row(TOS_ACT_POP,    3'd0, '0,      1'b1, mk_res(3'd7, VAL_MAX, 1, TOS_ERR_OK));
    add_row(TOS_ACT_POP,    3'd0, '0,      1'b1, mk_res(3'd0, '0, 0, TOS_ERR_OK));
    add_row(TOS_ACT_PUSH,   3'd5, VAL_ODD, 1'b0, '0);
    add_row(ACT_RSVD_6,     3'd7, VAL_MAX, 1'b1, mk_res(3'd5, VAL_ODD, 1, TOS_ERR_OK));
    add_row(ACT_RSVD_7,     3'd2, '0,      1'b1, mk_res(3'd5, VAL_ODD, 1, TOS_ERR_OK));
    add_row(TOS_ACT_DUP,    3'd0, '0,      1'b0, '0);
    add_row(TOS_ACT_PUSH,   3'd2, 64'h0123_4567_89AB_CDEF, 1'b0, '0);
    add_row(TOS_ACT_SWAP,   3'd0, '0,      1'b0, '0);
    add_row(TOS_ACT_ASSERT, 3'd5, VAL_ODD, 1'b0, '0);
    add_row(TOS_ACT_CLEAR,  3'd3, VAL_MAX, 1'b1, mk_res(3'd0, '0, 0, TOS_ERR_OK));
    add_row(TOS_ACT_CLEAR,  3'd0, '0,      1'b1, mk_res(3'd0, '0, 0, TOS_ERR_OK));
    add_row(TOS_ACT_POP,    3'd0, '0,      1'b1, mk_res(3'd0, '0, 0, TOS_ERR_EMPTY));
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].word, $urandom_range(0, 10), 1'b0, dir_rows[i].typed,
                dir_rows[i].want);
    end

    // Random bursts: fill to full, drain to empty, mixed traffic, some noise
    while (n_counted < N_WORDS) begin
      roll = $urandom_range(0, 9);
      mix  = roll < 3 ? MIX_FILL : roll < 6 ? MIX_DRAIN : roll < 9 ? MIX_BALANCED :
             MIX_NOISE;
      burst_len = $urandom_range(20, 120);
      no_idle   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < burst_len && n_counted < N_WORDS; i++) begin
        w     = rand_word(mix);
        drain = (n_counted == N_WORDS / 2) || ($urandom_range(0, 199) == 0);
        send_word(w, no_idle ? 0 : $urandom_range(0, 10), drain, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d stack words plus %0d reserved actions, %0d results checked.",
             n_counted, n_rsvd, n_checked);
    $display("Deepest stack %0d, %0d full rejects, %0d matching asserts.",
             max_depth, n_full, n_match);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
